// ===== rtl/core/apt_pkg.sv =====
// Package for the affine point transform: codes, item and divider lane types,
// and the one-bit restoring division step.
// No dependencies.
`default_nettype none
package apt_pkg;

  localparam int AREA_SIZE_DEF = 65536;
  localparam int DIV_STEPS     = 33;  // quotient bits

  // transform modes
  localparam logic [2:0] MODE_NONE    = 3'd0;
  localparam logic [2:0] MODE_MOVE    = 3'd1;
  localparam logic [2:0] MODE_STRETCH = 3'd2;
  localparam logic [2:0] MODE_ROTATE  = 3'd3;
  localparam logic [2:0] MODE_MIRROR  = 3'd4;
  localparam logic [2:0] MODE_SCALE   = 3'd5;

  // item kinds
  localparam logic [1:0] FUNC_POINT = 2'd0;
  localparam logic [1:0] FUNC_DIM   = 2'd1;
  localparam logic [1:0] FUNC_ANGLE = 2'd2;

  // register indexes
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_TRIG      = 3'd1;
  localparam logic [2:0] REG_DIVISOR   = 3'd2;
  localparam logic [2:0] REG_CENTRE    = 3'd3;
  localparam logic [2:0] REG_OFFSET    = 3'd4;
  localparam logic [2:0] REG_RECT      = 3'd5;
  localparam logic [2:0] REG_SCALE_NUM = 3'd6;
  localparam logic [2:0] REG_SCALE_DEN = 3'd7;

  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        px;
    logic [15:0]        py;
    logic [15:0]        dim;
    logic signed [15:0] ac;
    logic signed [15:0] as;
  } item_t;

  // one divider lane: dividend shifts out the top, quotient shifts in below
  typedef struct packed {
    logic [32:0] dq;
    logic [15:0] rem;
    logic [15:0] dv;
    logic        neg;
  } lane_t;

  function automatic lane_t div_step(lane_t l);
    lane_t       r;
    logic [16:0] t;
    logic [16:0] d;
    r = l;
    t = {l.rem, l.dq[32]};
    d = t - {1'b0, l.dv};
    if (t >= {1'b0, l.dv}) begin
      r.rem = d[15:0];
      r.dq  = {l.dq[31:0], 1'b1};
    end else begin
      r.rem = t[15:0];
      r.dq  = {l.dq[31:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/affine_point_transform.sv =====
// Top level of the affine point transform: input register, multiply stage,
// lane setup, a 33-stage division pipeline and the output register.
// Depends on apt_pkg.
//
// One item enters per cycle while the pipeline advances; the two restoring
// dividers produce one quotient bit per stage over 33 stages, after an
// input, a multiply and a setup stage and before the output register. The
// whole pipeline advances together whenever the output register is empty or
// its result is taken, so in_ready follows out_ready. Configuration must be
// written only while the pipeline is empty.
`default_nettype none
module affine_point_transform #(
  parameter int AREA_SIZE = apt_pkg::AREA_SIZE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_func,
  input  wire logic [15:0]        in_point_x,
  input  wire logic [15:0]        in_point_y,
  input  wire logic [15:0]        in_dim_value,
  input  wire logic signed [15:0] in_ang_cos,
  input  wire logic signed [15:0] in_ang_sin,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_x,
  output logic [15:0]             out_y,
  output logic [15:0]             out_dim,
  output logic signed [15:0]      out_cos,
  output logic signed [15:0]      out_sin,
  output logic                    out_outside
);

  localparam int NS = apt_pkg::DIV_STEPS;
  localparam logic signed [34:0] AREA_LIM = 35'(AREA_SIZE);

  // configuration registers
  logic [2:0]         mode_r;
  logic signed [15:0] kc_r, ks_r, div_r;
  logic [15:0]        cx_r, cy_r;
  logic signed [15:0] offx_r, offy_r;
  logic [63:0]        rect_r;
  logic [15:0]        num_r, den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= apt_pkg::MODE_NONE;
      kc_r   <= '0;
      ks_r   <= '0;
      div_r  <= '0;
      cx_r   <= '0;
      cy_r   <= '0;
      offx_r <= '0;
      offy_r <= '0;
      rect_r <= '0;
      num_r  <= 16'd1;
      den_r  <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        apt_pkg::REG_MODE:      mode_r <= cfg_wdata[2:0];
        apt_pkg::REG_TRIG:      begin kc_r <= cfg_wdata[31:16]; ks_r <= cfg_wdata[15:0]; end
        apt_pkg::REG_DIVISOR:   div_r <= cfg_wdata[15:0];
        apt_pkg::REG_CENTRE:    begin cx_r <= cfg_wdata[31:16]; cy_r <= cfg_wdata[15:0]; end
        apt_pkg::REG_OFFSET:    begin offx_r <= cfg_wdata[31:16]; offy_r <= cfg_wdata[15:0]; end
        apt_pkg::REG_RECT:      rect_r <= cfg_wdata;
        apt_pkg::REG_SCALE_NUM: num_r <= cfg_wdata[15:0];
        apt_pkg::REG_SCALE_DEN: den_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage A: input register
  logic            va_r;
  apt_pkg::item_t  ia_r;

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (adv) va_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) ia_r <= '{in_func, in_point_x, in_point_y, in_dim_value, in_ang_cos, in_ang_sin};
  end

  // stage B: products
  logic signed [16:0] opa, opb;
  logic [15:0]        magx, magy;
  logic               gtx, gty;
  logic signed [16:0] dxs, dys;

  always_comb begin
    dxs = $signed({1'b0, ia_r.px}) - $signed({1'b0, cx_r});
    dys = $signed({1'b0, ia_r.py}) - $signed({1'b0, cy_r});
    if (ia_r.func == apt_pkg::FUNC_ANGLE) begin
      opa = 17'(ia_r.ac);
      opb = 17'(ia_r.as);
    end else begin
      opa = dxs;
      opb = dys;
    end
    if (ia_r.func == apt_pkg::FUNC_DIM) begin
      magx = ia_r.dim;
      gtx  = ia_r.dim != 16'd0;
    end else begin
      magx = dxs[16] ? 16'(-dxs) : dxs[15:0];
      gtx  = ia_r.px > cx_r;
    end
    magy = dys[16] ? 16'(-dys) : dys[15:0];
    gty  = ia_r.py > cy_r;
  end

  logic                vb_r;
  apt_pkg::item_t      ib_r;
  logic signed [32:0]  p1_r, p2_r, p3_r, p4_r;
  logic [31:0]         sqx_r, sqy_r;
  logic                gtx_r, gty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else if (adv) vb_r <= va_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ib_r  <= ia_r;
      p1_r  <= opa * kc_r;
      p2_r  <= opb * ks_r;
      p3_r  <= opa * ks_r;
      p4_r  <= opb * kc_r;
      sqx_r <= num_r * magx;
      sqy_r <= num_r * magy;
      gtx_r <= gtx;
      gty_r <= gty;
    end
  end

  // stage C: lane setup (sums, magnitudes, signs)
  logic signed [33:0] sumx, sumy;
  logic [16:0]        dmag;
  apt_pkg::lane_t     lx_nxt, ly_nxt;

  always_comb begin
    if (mode_r == apt_pkg::MODE_ROTATE) begin
      sumx = 34'(p1_r) - 34'(p2_r);
      sumy = 34'(p3_r) + 34'(p4_r);
    end else begin
      sumx = 34'(p1_r) + 34'(p2_r);
      sumy = 34'(p3_r) - 34'(p4_r);
    end
    dmag = div_r[15] ? -17'(div_r) : 17'(div_r);
    if (mode_r == apt_pkg::MODE_SCALE) begin
      lx_nxt = '{{1'b0, sqx_r}, 16'd0, den_r, !gtx_r};
      ly_nxt = '{{1'b0, sqy_r}, 16'd0, den_r, !gty_r};
    end else begin
      lx_nxt.dq  = sumx[33] ? 33'(-sumx) : sumx[32:0];
      lx_nxt.rem = '0;
      lx_nxt.dv  = dmag[15:0];
      lx_nxt.neg = sumx[33] ^ div_r[15];
      ly_nxt.dq  = sumy[33] ? 33'(-sumy) : sumy[32:0];
      ly_nxt.rem = '0;
      ly_nxt.dv  = dmag[15:0];
      ly_nxt.neg = sumy[33] ^ div_r[15];
    end
  end

  // division pipeline: index 0 is the setup register, NS the last step
  logic           vd_r [NS+1];
  apt_pkg::item_t id_r [NS+1];
  apt_pkg::lane_t lx_r [NS+1];
  apt_pkg::lane_t ly_r [NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) vd_r[i] <= 1'b0;
    end else if (adv) begin
      vd_r[0] <= vb_r;
      for (int i = 1; i <= NS; i++) vd_r[i] <= vd_r[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      id_r[0] <= ib_r;
      lx_r[0] <= lx_nxt;
      ly_r[0] <= ly_nxt;
      for (int i = 1; i <= NS; i++) begin
        id_r[i] <= id_r[i-1];
        lx_r[i] <= apt_pkg::div_step(lx_r[i-1]);
        ly_r[i] <= apt_pkg::div_step(ly_r[i-1]);
      end
    end
  end

  // final stage: signs, centre, area check and result select
  apt_pkg::item_t     it;
  logic signed [34:0] vx, vy, nx, ny;
  logic               use_div, scaling, add, in_rect, ok;
  logic [15:0]        rx, ry, rdim;
  logic [15:0]        rcos, rsin;
  logic               routside;

  always_comb begin
    it      = id_r[NS];
    vx      = lx_r[NS].neg ? -$signed({2'b0, lx_r[NS].dq}) : $signed({2'b0, lx_r[NS].dq});
    vy      = ly_r[NS].neg ? -$signed({2'b0, ly_r[NS].dq}) : $signed({2'b0, ly_r[NS].dq});
    scaling = num_r != den_r;
    use_div = ((mode_r == apt_pkg::MODE_ROTATE || mode_r == apt_pkg::MODE_MIRROR)
               && div_r != 16'sd0);
    in_rect = it.px >= rect_r[63:48] && it.px <= rect_r[31:16] &&
              it.py >= rect_r[47:32] && it.py <= rect_r[15:0];
    add     = (mode_r == apt_pkg::MODE_MOVE) || (mode_r == apt_pkg::MODE_STRETCH && in_rect);
    rx = '0; ry = '0; rdim = '0; rcos = '0; rsin = '0; routside = 1'b0;
    nx = '0; ny = '0; ok = 1'b1;
    case (it.func)
      apt_pkg::FUNC_POINT: begin
        if (add) begin
          rx = it.px + offx_r;
          ry = it.py + offy_r;
        end else if (use_div || (mode_r == apt_pkg::MODE_SCALE && scaling)) begin
          nx = 35'(cx_r) + vx;
          ny = 35'(cy_r) + vy;
          ok = nx >= 0 && nx < AREA_LIM && ny >= 0 && ny < AREA_LIM &&
               !(mode_r == apt_pkg::MODE_SCALE && den_r == 16'd0);
          if (ok) begin
            rx = nx[15:0];
            ry = ny[15:0];
          end else routside = 1'b1;
        end else begin
          rx = it.px;
          ry = it.py;
        end
      end
      apt_pkg::FUNC_DIM: begin
        if (mode_r == apt_pkg::MODE_SCALE && scaling) begin
          ok = vx >= 0 && vx < AREA_LIM && den_r != 16'd0;
          if (ok) rdim = vx[15:0];
          else routside = 1'b1;
        end else rdim = it.dim;
      end
      apt_pkg::FUNC_ANGLE: begin
        if (use_div) begin
          rcos = vx[15:0];
          rsin = vy[15:0];
        end else begin
          rcos = it.ac;
          rsin = it.as;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= vd_r[NS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_x       <= rx;
      out_y       <= ry;
      out_dim     <= rdim;
      out_cos     <= rcos;
      out_sin     <= rsin;
      out_outside <= routside;
    end
  end

  // checks
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outside) |-> (out_x == 16'd0 && out_y == 16'd0 && out_dim == 16'd0))
    else $error("outside result carries nonzero coordinates");
  a_outside_no_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outside) |-> (out_cos == 16'sd0 && out_sin == 16'sd0))
    else $error("outside flagged with angle data");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(out_outside)))
    else $error("stalled result changed");

endmodule
`default_nettype wire
